// File: rtl/tci_pkg.sv
package tci_pkg;

    localparam int RPM_W      = 14;
    localparam int TQ_W       = 16;
    localparam int SLOPE_W    = 32;
    localparam int DIVIDEND_W = 32;
    localparam int DIVISOR_W  = 14;
    localparam int PROD_W     = RPM_W + 1 + SLOPE_W;

    localparam logic [RPM_W-1:0] RPM_MAX = {RPM_W{1'b1}};

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Source of the next result word.
    localparam logic [2:0] SEL_LOAD   = 3'd0;
    localparam logic [2:0] SEL_FULL   = 3'd1;
    localparam logic [2:0] SEL_EMPTY  = 3'd2;
    localparam logic [2:0] SEL_LAST   = 3'd3;
    localparam logic [2:0] SEL_INTERP = 3'd4;

    typedef struct packed {
        logic                    command;
        logic [RPM_W-1:0]        rpm;
        logic signed [TQ_W-1:0]  torque;
        logic                    top_gear;
    } t_in_item;

    typedef struct packed {
        logic signed [TQ_W-1:0]  torque_out;
        logic [RPM_W-1:0]        effective_rpm;
        logic [1:0]              status;
    } t_out_item;

    typedef struct packed {
        logic       capture;
        logic       load_wr;
        logic       div_start;
        logic       slope_wr;
        logic       eff_calc;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd_en;
        logic       shift_prev;
        logic       mul_go;
        logic       out_load;
        logic [2:0] out_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic is_eval;
        logic empty;
        logic full;
        logic div_done;
        logic idx_zero;
        logic scan_end;
        logic match;
    } t_dp_sts;

endpackage

// File: rtl/tci_div.sv
module tci_div (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [tci_pkg::DIVIDEND_W-1:0]     i_dividend,
    input  logic [tci_pkg::DIVISOR_W-1:0]      i_divisor,
    output logic [tci_pkg::DIVIDEND_W-1:0]     o_quot,
    output logic                               o_done
);
    import tci_pkg::*;

    localparam int CNT_W = $clog2(DIVIDEND_W);

    logic [DIVIDEND_W-1:0] r_q;
    logic [DIVISOR_W:0]    r_rem;
    logic [DIVISOR_W-1:0]  r_dvs;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_busy;
    logic                  r_done;

    logic [DIVISOR_W:0]    w_trial;
    logic                  w_fits;

    // Restoring division, one quotient bit per cycle, MSB first.
    assign w_trial = {r_rem[DIVISOR_W-1:0], r_q[DIVIDEND_W-1]};
    assign w_fits  = w_trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIVIDEND_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_fits ? (w_trial - {1'b0, r_dvs}) : w_trial;
            r_q   <= {r_q[DIVIDEND_W-2:0], w_fits};
        end
    end

    assign o_quot = r_q;
    assign o_done = r_done;

endmodule

// File: rtl/tci_dp.sv
module tci_dp #(
    parameter int MAX_POINTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tci_pkg::t_in_item    i_item,
    input  tci_pkg::t_dp_cmd     i_cmd,
    output tci_pkg::t_dp_sts     o_sts,
    output tci_pkg::t_out_item   o_out
);
    import tci_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    logic [RPM_W-1:0]          mem_rpm   [MAX_POINTS];
    logic signed [TQ_W-1:0]    mem_tq    [MAX_POINTS];
    logic signed [SLOPE_W-1:0] mem_slope [MAX_POINTS];

    t_in_item                  r_item;
    t_out_item                 r_out;
    logic [CW-1:0]             r_count;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_seg_idx;
    logic [RPM_W-1:0]          r_first_rpm;
    logic [RPM_W-1:0]          r_last_rpm;
    logic signed [TQ_W-1:0]    r_last_tq;
    logic [RPM_W-1:0]          r_eff;
    logic                      r_eff_big;
    logic [RPM_W-1:0]          r_rd_rpm;
    logic signed [TQ_W-1:0]    r_rd_tq;
    logic signed [SLOPE_W-1:0] r_rd_slope;
    logic [RPM_W-1:0]          r_prev_rpm;
    logic signed [TQ_W-1:0]    r_prev_tq;
    logic signed [SLOPE_W-1:0] r_prev_slope;
    logic signed [PROD_W-1:0]  r_prod;
    logic                      r_neg;
    logic                      r_dr_zero;

    logic [RPM_W:0]            w_dr;
    logic [TQ_W:0]             w_dt;
    logic [RPM_W:0]            w_dr_abs;
    logic [TQ_W:0]             w_dt_abs;
    logic [DIVIDEND_W-1:0]     w_quot;
    logic                      w_div_done;
    logic signed [SLOPE_W-1:0] w_slope;
    logic [RPM_W-1:0]          w_eff;
    logic                      w_eff_big;
    logic [RPM_W-1:0]          w_diff;
    logic signed [PROD_W:0]    w_round;
    logic signed [SLOPE_W-1:0] w_step;
    logic signed [SLOPE_W:0]   w_sum;
    logic signed [TQ_W-1:0]    w_interp;

    // Differences against the previous point, taken before it is replaced.
    assign w_dr     = {1'b0, r_item.rpm} - {1'b0, r_last_rpm};
    assign w_dt     = {r_item.torque[TQ_W-1], r_item.torque} - {r_last_tq[TQ_W-1], r_last_tq};
    assign w_dr_abs = w_dr[RPM_W] ? -w_dr : w_dr;
    assign w_dt_abs = w_dt[TQ_W] ? -w_dt : w_dt;

    tci_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_dt_abs[TQ_W-1:0], {(DIVIDEND_W - TQ_W){1'b0}}}),
        .i_divisor  (w_dr_abs[DIVISOR_W-1:0]),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // Apply the sign to the quotient magnitude and saturate to 32 signed bits; a zero rpm step gives a zero slope.
    always_comb begin
        if (r_dr_zero) begin
            w_slope = '0;
        end else if (!r_neg) begin
            w_slope = w_quot[DIVIDEND_W-1] ? {1'b0, {(SLOPE_W-1){1'b1}}} : w_quot;
        end else if (w_quot > {1'b1, {(SLOPE_W-1){1'b0}}}) begin
            w_slope = {1'b1, {(SLOPE_W-1){1'b0}}};
        end else begin
            w_slope = -w_quot;
        end
    end

    // Clamp the query rpm. Below the last point at rpm zero, the upper clamp
    // wraps past every stored point, so no segment can match.
    always_comb begin
        w_eff_big = 1'b0;
        if (r_item.rpm < r_first_rpm) begin
            w_eff = (r_first_rpm == RPM_MAX) ? RPM_MAX : r_first_rpm + RPM_W'(1);
        end else if (r_item.rpm > r_last_rpm && !r_item.top_gear) begin
            w_eff     = r_last_rpm - RPM_W'(1);
            w_eff_big = (r_last_rpm == '0);
        end else begin
            w_eff = r_item.rpm;
        end
    end

    assign w_diff = r_eff - r_prev_rpm;

    // Round half up, then add to the segment start torque and saturate.
    assign w_round  = {r_prod[PROD_W-1], r_prod} + (PROD_W + 1)'(32768);
    assign w_step   = w_round[SLOPE_W+15:16];
    assign w_sum    = {{(SLOPE_W - TQ_W + 1){r_prev_tq[TQ_W-1]}}, r_prev_tq}
                    + {w_step[SLOPE_W-1], w_step};

    always_comb begin
        if (w_sum > (SLOPE_W + 1)'(32767)) begin
            w_interp = {1'b0, {(TQ_W-1){1'b1}}};
        end else if (w_sum < -(SLOPE_W + 1)'(32768)) begin
            w_interp = {1'b1, {(TQ_W-1){1'b0}}};
        end else begin
            w_interp = w_sum[TQ_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_wr) begin
            r_count <= r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_item;
        end
        if (i_cmd.load_wr) begin
            mem_rpm[r_count[AW-1:0]] <= r_item.rpm;
            mem_tq[r_count[AW-1:0]]  <= r_item.torque;
            r_last_rpm               <= r_item.rpm;
            r_last_tq                <= r_item.torque;
            r_seg_idx                <= r_count[AW-1:0] - AW'(1);
            if (r_count == '0) begin
                r_first_rpm <= r_item.rpm;
            end
        end
        if (i_cmd.div_start) begin
            r_neg     <= w_dr[RPM_W] ^ w_dt[TQ_W];
            r_dr_zero <= (w_dr == '0);
        end
        if (i_cmd.slope_wr) begin
            mem_slope[r_seg_idx] <= w_slope;
        end
        if (i_cmd.eff_calc) begin
            r_eff     <= w_eff;
            r_eff_big <= w_eff_big;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= r_idx + AW'(1);
        end
        if (i_cmd.rd_en) begin
            r_rd_rpm   <= mem_rpm[r_idx];
            r_rd_tq    <= mem_tq[r_idx];
            r_rd_slope <= mem_slope[r_idx];
        end
        if (i_cmd.shift_prev) begin
            r_prev_rpm   <= r_rd_rpm;
            r_prev_tq    <= r_rd_tq;
            r_prev_slope <= r_rd_slope;
        end
        if (i_cmd.mul_go) begin
            r_prod <= $signed({1'b0, w_diff}) * r_prev_slope;
        end
        if (i_cmd.out_load) begin
            unique case (i_cmd.out_sel)
                SEL_LOAD:   r_out <= '{torque_out: '0, effective_rpm: '0, status: STATUS_OK};
                SEL_FULL:   r_out <= '{torque_out: '0, effective_rpm: '0, status: STATUS_FULL};
                SEL_EMPTY:  r_out <= '{torque_out: '0, effective_rpm: r_item.rpm,
                                       status: STATUS_EMPTY};
                SEL_LAST:   r_out <= '{torque_out: r_last_tq, effective_rpm: r_eff,
                                       status: STATUS_OK};
                SEL_INTERP: r_out <= '{torque_out: w_interp, effective_rpm: r_eff,
                                       status: STATUS_OK};
                default:    r_out <= r_out;
            endcase
        end
    end

    assign o_sts.is_eval  = (r_item.command == CMD_EVAL);
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.full     = (r_count == CW'(MAX_POINTS));
    assign o_sts.div_done = w_div_done;
    assign o_sts.idx_zero = (r_idx == '0);
    assign o_sts.scan_end = ((CW'(r_idx) + CW'(1)) == r_count);
    assign o_sts.match    = !r_eff_big && (r_eff >= r_prev_rpm) && (r_eff <= r_rd_rpm);

    assign o_out = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_POINTS))
        else $error("point count exceeds table depth");

    a_mul_in_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mul_go |-> (r_eff >= r_prev_rpm && !r_eff_big))
        else $error("interpolation started outside the segment");

endmodule

// File: rtl/tci_ctrl.sv
module tci_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    input  tci_pkg::t_dp_sts   i_sts,
    output tci_pkg::t_dp_cmd   o_cmd
);
    import tci_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_DIV    = 3'd2;
    localparam logic [2:0] S_RD     = 3'd3;
    localparam logic [2:0] S_CMP    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_OUT    = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic [2:0] r_sel;
    logic [2:0] n_sel;
    logic       r_out_vld;
    logic       n_out_vld;
    t_dp_cmd    w_cmd;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        w_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                if (!i_sts.is_eval) begin
                    if (i_sts.full) begin
                        n_sel   = SEL_FULL;
                        n_state = S_OUT;
                    end else begin
                        w_cmd.load_wr = 1'b1;
                        if (i_sts.empty) begin
                            n_sel   = SEL_LOAD;
                            n_state = S_OUT;
                        end else begin
                            w_cmd.div_start = 1'b1;
                            n_state         = S_DIV;
                        end
                    end
                end else if (i_sts.empty) begin
                    n_sel   = SEL_EMPTY;
                    n_state = S_OUT;
                end else begin
                    w_cmd.eff_calc = 1'b1;
                    w_cmd.idx_clr  = 1'b1;
                    n_state        = S_RD;
                end
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    w_cmd.slope_wr = 1'b1;
                    n_sel          = SEL_LOAD;
                    n_state        = S_OUT;
                end
            end
            S_RD: begin
                w_cmd.rd_en = 1'b1;
                n_state     = S_CMP;
            end
            S_CMP: begin
                // The first entry read only seeds the previous-point registers.
                if (!i_sts.idx_zero && i_sts.match) begin
                    w_cmd.mul_go = 1'b1;
                    n_sel        = SEL_INTERP;
                    n_state      = S_MUL;
                end else if (i_sts.scan_end) begin
                    n_sel   = SEL_LAST;
                    n_state = S_OUT;
                end else begin
                    w_cmd.shift_prev = 1'b1;
                    w_cmd.idx_inc    = 1'b1;
                    n_state          = S_RD;
                end
            end
            S_MUL: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_vld || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        w_cmd.out_sel = r_sel;
    end

    always_comb begin
        if (w_cmd.out_load) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_sel     <= SEL_LOAD;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_sel     <= n_sel;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

    a_load_free_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_vld || i_out_ready))
        else $error("result register overwritten before its transfer");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item taken while one is in progress");

    a_slope_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.slope_wr |-> i_sts.div_done)
        else $error("slope written before the divide finished");

endmodule

// File: rtl/torque_curve_interpolator.sv
// Piecewise linear torque curve lookup.
// Input channel (i_in_valid / o_in_ready / i_in_data): a load item appends
// one (rpm, torque) point and computes the slope of the segment it closes;
// an evaluate item clamps the query rpm and interpolates on the first
// segment that contains it. Every item gives exactly one result on the
// output channel (o_out_valid / i_out_ready / o_out_data).
// One item is processed at a time. For the first point loaded the sequencer
// goes from decode straight to the output state; a later load waits in the
// divide state for the radix-2 slope divider (one quotient bit per cycle over
// 32 bits). An evaluate scans the curve points in order, with a read step and
// a compare step for each, as the single-port point memory is read once per
// scan step, and a multiply step when a segment matches; where none matches,
// the result is the last point's torque. The input is ready again in the cycle
// the result is registered. A load on a full table only reports full status.
// The result sits in an output register, so a new item is taken while the
// previous result waits; if the receiver stalls, the next result holds in
// the sequencer until the register frees.
// Reset empties the curve; point storage itself is not cleared.
module torque_curve_interpolator #(
    parameter int MAX_POINTS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tci_pkg::t_in_item    i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tci_pkg::t_out_item   o_out_data
);
    import tci_pkg::*;

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    tci_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    tci_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_in_data),
        .i_cmd   (w_cmd),
        .o_sts   (w_sts),
        .o_out   (o_out_data)
    );

endmodule

// File: dv/torque_curve_interpolator_tb.sv
`timescale 1ns / 100ps

module torque_curve_interpolator_tb;
    import tci_pkg::*;

    localparam int MAX_POINTS     = 16;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int REPORT_LINES   = 100;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      out_ready = 1'b0;
    t_in_item  in_data = '0;
    logic      o_in_ready;
    logic      o_out_valid;
    t_out_item o_out_data;

    // Curve as the predictor sees it.
    logic [RPM_W-1:0]        curve_rpm [MAX_POINTS];
    logic signed [TQ_W-1:0]  curve_torque [MAX_POINTS];
    logic signed [31:0]      curve_slope [MAX_POINTS];
    int                      curve_len = 0;

    t_out_item pending_results[$];
    t_out_item want;
    int        mismatch_count = 0;
    int        result_count = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    torque_curve_interpolator #(
        .MAX_POINTS(MAX_POINTS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_data (o_out_data)
    );

    always #1 clk = ~clk;

    function automatic t_out_item predict_result(input t_in_item item);
        t_out_item   res;
        longint      dr;
        longint      dt;
        longint      quot;
        longint      prod;
        longint      acc;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] eff;
        bit          found;
        int          idx;
        res = '0;
        found = 1'b0;
        if (item.command == CMD_LOAD) begin
            if (curve_len >= MAX_POINTS) begin
                res.status = STATUS_FULL;
            end else begin
                curve_rpm[curve_len] = item.rpm;
                curve_torque[curve_len] = $signed(item.torque);
                curve_slope[curve_len] = '0;
                if (curve_len > 0) begin
                    dr = longint'(item.rpm) - longint'(curve_rpm[curve_len-1]);
                    dt = longint'($signed(item.torque)) - longint'(curve_torque[curve_len-1]);
                    quot = 0;
                    if (dr != 0) quot = (dt * 65536) / dr;
                    if (quot > 64'sd2147483647) quot = 64'sd2147483647;
                    if (quot < -64'sd2147483648) quot = -64'sd2147483648;
                    curve_slope[curve_len-1] = quot[31:0];
                end
                curve_len++;
            end
        end else if (curve_len == 0) begin
            res.status = STATUS_EMPTY;
            res.effective_rpm = item.rpm;
        end else begin
            lo = 32'(curve_rpm[0]);
            hi = 32'(curve_rpm[curve_len-1]);
            // An upper clamp on a curve ending at rpm 0 wraps below zero, so
            // eff stays 32 bits wide for the segment scan.
            if (32'(item.rpm) < lo) begin
                eff = (lo + 1 > 32'(RPM_MAX)) ? 32'(RPM_MAX) : lo + 1;
            end else if (32'(item.rpm) > hi && !item.top_gear) begin
                eff = hi - 32'd1;
            end else begin
                eff = 32'(item.rpm);
            end
            acc = longint'(curve_torque[curve_len-1]);
            for (idx = 0; idx + 1 < curve_len && !found; idx++) begin
                if (eff >= 32'(curve_rpm[idx]) && eff <= 32'(curve_rpm[idx+1])) begin
                    prod = longint'(eff - 32'(curve_rpm[idx])) * longint'(curve_slope[idx]);
                    acc = longint'(curve_torque[idx]) + ((prod + 32768) >>> 16);
                    if (acc > 32767) acc = 32767;
                    if (acc < -32768) acc = -32768;
                    found = 1'b1;
                end
            end
            res.torque_out = acc[TQ_W-1:0];
            res.effective_rpm = eff[RPM_W-1:0];
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint exp_val);
        mismatch_count++;
        if (mismatch_count <= REPORT_LINES) begin
            $display("result %0d: %s is %0d, should be %0d", result_count, what, got, exp_val);
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result, torque_out",
                                $signed(o_out_data.torque_out), 0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.torque_out !== want.torque_out)
                    report_mismatch("torque_out", $signed(o_out_data.torque_out),
                                    $signed(want.torque_out));
                if (o_out_data.effective_rpm !== want.effective_rpm)
                    report_mismatch("effective_rpm", o_out_data.effective_rpm,
                                    want.effective_rpm);
                if (o_out_data.status !== want.status)
                    report_mismatch("status", o_out_data.status, want.status);
            end
            result_count++;
        end
    end

    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Ends the run when neither channel has made a transfer for too long.
    always @(posedge clk) begin
        if ((in_valid && o_in_ready) || (o_out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer,
    // leaving valid high so back-to-back items need no second assignment.
    task automatic send_item(input t_in_item item);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data <= item;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        pending_results.insert(pending_results.size(), predict_result(item));
        @(negedge clk);
    endtask

    task automatic load_point(input int rpm, input int tq);
        t_in_item item;
        item.command = CMD_LOAD;
        item.rpm = RPM_W'(rpm);
        item.torque = TQ_W'(tq);
        item.top_gear = 1'($urandom_range(1));
        send_item(item);
    endtask

    task automatic eval_at(input int rpm, input logic top);
        t_in_item item;
        item.command = CMD_EVAL;
        item.rpm = RPM_W'(rpm);
        item.torque = TQ_W'($urandom);
        item.top_gear = top;
        send_item(item);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    function automatic int rand_query_rpm();
        int pick;
        int val;
        pick = $urandom_range(9);
        if (curve_len == 0 || pick < 2) return int'($urandom_range(RPM_MAX));
        if (pick < 5) begin
            val = int'(curve_rpm[$urandom_range(curve_len - 1)]) + int'($urandom_range(2)) - 1;
        end else begin
            val = int'($urandom_range(int'(curve_rpm[curve_len-1]) + 200));
        end
        if (val < 0) val = 0;
        if (val > int'(RPM_MAX)) val = int'(RPM_MAX);
        return val;
    endfunction

    task automatic test_empty_table();
        eval_at(int'(RPM_MAX), 1'b1);
        eval_at(0, 1'b0);
    endtask

    task automatic test_single_point();
        load_point(200, 32767);
        eval_at(200, 1'b0);
        eval_at(50, 1'b0);
        eval_at(9000, 1'b0);
        eval_at(9000, 1'b1);
    endtask

    // The second point goes below the first, so the curve ends at rpm 0 and
    // the upper clamp lands below zero.
    task automatic test_descending_curve();
        load_point(0, -32768);
        eval_at(300, 1'b0);
        eval_at(100, 1'b0);
    endtask

    // Slopes that saturate both ways, a zero-width segment that a wider one
    // ahead of it shadows, and plain interpolation.
    task automatic test_segments();
        load_point(1000, -32768);
        load_point(1001, 32767);
        load_point(1002, -32768);
        load_point(1002, 100);
        load_point(2000, 5000);
        eval_at(1000, 1'b0);
        eval_at(1001, 1'b0);
        eval_at(1002, 1'b0);
        eval_at(1500, 1'b1);
        eval_at(2000, 1'b0);
        eval_at(3000, 1'b0);
        eval_at(3000, 1'b1);
        eval_at(150, 1'b0);
    endtask

    task automatic test_fill_random();
        int last;
        int next_rpm;
        int pick;
        set_idling(14, 14);
        while (curve_len < MAX_POINTS) begin
            if ($urandom_range(9) < 7) begin
                eval_at(rand_query_rpm(), 1'($urandom_range(1)));
            end else begin
                last = int'(curve_rpm[curve_len-1]);
                pick = $urandom_range(9);
                if (pick == 0) begin
                    next_rpm = last;
                end else if (pick == 1) begin
                    next_rpm = last - int'($urandom_range(100, 1));
                end else begin
                    next_rpm = last + int'($urandom_range(1500, 1));
                end
                if (next_rpm < 0) next_rpm = 0;
                if (next_rpm > int'(RPM_MAX)) next_rpm = int'(RPM_MAX);
                load_point(next_rpm, int'($urandom_range(16'hFFFF)));
            end
        end
    endtask

    task automatic test_table_full();
        set_idling(0, 0);
        load_point(0, 0);
        load_point(int'(RPM_MAX), -1);
        eval_at(int'(RPM_MAX), 1'b1);
    endtask

    task automatic test_random_traffic();
        int send_pct [4] = '{0, 69, 0, 14};
        int recv_pct [4] = '{0, 0, 69, 14};
        int phase;
        int n;
        for (phase = 0; phase < 4; phase++) begin
            // The sender holds off until the block has emptied out.
            wait_drained();
            set_idling(send_pct[phase], recv_pct[phase]);
            for (n = 0; n < 170; n++) begin
                if ($urandom_range(99) < 85) begin
                    eval_at(rand_query_rpm(), 1'($urandom_range(1)));
                end else begin
                    load_point(int'($urandom_range(RPM_MAX)), int'($urandom_range(16'hFFFF)));
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_empty_table();
        test_single_point();
        test_descending_curve();
        test_segments();
        test_fill_random();
        test_table_full();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
